// File: src/phr_pkg.sv
// ============================================================================
// phr_pkg
// Shared widths, payload types and segment codes for the packed HSL to RGB
// converter.
// ============================================================================
package phr_pkg;

   localparam int unsigned PACKED_W = 16;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned LANES    = 3;

   // Hue position inside one turn, in units of 1/384 turn (0..384).
   typedef logic [8:0]          hue_pos_type;
   // Lightness and chroma terms, in units of 1/2048.
   typedef logic [10:0]         frac_type;
   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [PACKED_W-1:0] packed_type;

   // Which piece of the piecewise hue curve a channel falls on.
   typedef enum logic [1:0] {
      SEG_RISE = 2'd0,
      SEG_HIGH = 2'd1,
      SEG_FALL = 2'd2,
      SEG_LOW  = 2'd3
   } seg_type;

endpackage

// File: src/phr_if.sv
// ============================================================================
// phr_if
// Valid/ready channels for the packed colour input and the RGB result.
// ============================================================================
interface phr_req_if;
   logic                valid;
   logic                ready;
   phr_pkg::packed_type packed_color;

   modport source (output valid, output packed_color, input ready);
   modport sink   (input valid, input packed_color, output ready);
endinterface

interface phr_rsp_if;
   logic              valid;
   logic              ready;
   phr_pkg::chan_type red;
   phr_pkg::chan_type green;
   phr_pkg::chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/packed_hsl_to_rgb.sv
// ============================================================================
// packed_hsl_to_rgb
// Converts one packed 6/3/7-bit HSL colour per beat into 8-bit red, green and
// blue channels, exactly as rational arithmetic would give them.
// ============================================================================
//
//   channel   direction  payload                         beat
//   --------  ---------  ------------------------------  ----------------
//   req_beat  in         packed_color[15:0]              one colour
//   rsp_beat  out        red[7:0], green[7:0], blue[7:0] one RGB triple
//
// The datapath is four register stages deep, and a new colour is taken in
// every cycle unless a stall on rsp_beat has filled every stage.
// Each stage advances when it is empty or when the stage after it advances,
// so a stall on rsp_beat fills bubbles first and then holds every item.
// Reset is synchronous and clears only the stage valid bits.
//
// Arithmetic: with lightness L, chroma terms and hue positions expressed in
// integers (1/2048 for levels, 1/384 turn for hue), each channel value times
// 2^17 is 64*p + span*f, where f is the hue distance on a sloped piece. The
// channel is then that sum shifted right by nine bits, clamped to 255.
// ============================================================================
module packed_hsl_to_rgb (
   input logic         clock,
   input logic         reset,
   phr_req_if.sink     req_beat,
   phr_rsp_if.source   rsp_beat
);

   // ------------------------------------------------------------------------
   // Stage enables. A stage may load when it is empty or is being drained.
   // ------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_beat.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_beat.ready = en1;

   assign v1_in = en1 ? req_beat.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: unpack, form lightness times odd saturation, and place each
   // channel's hue on the turn. Red leads green by a third, blue trails it.
   // ------------------------------------------------------------------------
   logic [6:0]          lit_in, lit1_ff;
   logic [3:0]          sodd_in, sodd1_ff;
   phr_pkg::frac_type   ls_in, ls1_ff;
   phr_pkg::hue_pos_type t1_in [phr_pkg::LANES];
   phr_pkg::hue_pos_type t1_ff [phr_pkg::LANES];

   always_comb begin
      logic [5:0] hue;
      logic [9:0] h3;
      logic [9:0] tr;
      lit_in  = req_beat.packed_color[6:0];
      sodd_in = {req_beat.packed_color[9:7], 1'b1};
      hue     = req_beat.packed_color[15:10];
      ls_in   = 11'(lit_in) * 11'(sodd_in);
      // Three times the odd hue code: hue position in 1/384 turn.
      h3      = 10'({hue, 1'b1}) * 10'd3;
      tr      = h3 + 10'd128;
      // A red position above one full turn wraps back by one turn.
      t1_in[0] = (tr > 10'd384) ? 9'(tr - 10'd384) : 9'(tr);
      t1_in[1] = 9'(h3);
      // A blue position below zero wraps forward by one turn.
      t1_in[2] = (h3 < 10'd128) ? 9'(h3 + 10'd256) : 9'(h3 - 10'd128);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         lit1_ff  <= lit_in;
         sodd1_ff <= sodd_in;
         ls1_ff   <= ls_in;
         t1_ff    <= t1_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: the two HSL levels a (top) and p (bottom), their difference,
   // and the piece of the hue curve each channel falls on.
   // ------------------------------------------------------------------------
   phr_pkg::frac_type    a_in, a2_ff;
   phr_pkg::frac_type    p_in, p2_ff;
   phr_pkg::frac_type    span_in, span2_ff;
   phr_pkg::seg_type     seg_in [phr_pkg::LANES];
   phr_pkg::seg_type     seg2_ff [phr_pkg::LANES];
   phr_pkg::hue_pos_type t2_ff [phr_pkg::LANES];

   always_comb begin
      logic [11:0] lvl;
      logic [11:0] sat_lvl;
      logic [11:0] a_w;
      logic [11:0] p_w;
      lvl     = {1'b0, lit1_ff, 4'b0000};
      sat_lvl = {1'b0, sodd1_ff, 7'b0000000};
      // Lower half of lightness: a = l + l*s; upper half: a = l + s - l*s.
      if (lit1_ff[6]) begin
         a_w = lvl + sat_lvl - 12'(ls1_ff);
      end else begin
         a_w = lvl + 12'(ls1_ff);
      end
      p_w     = {lvl[10:0], 1'b0} - a_w;
      a_in    = a_w[10:0];
      p_in    = p_w[10:0];
      span_in = a_in - p_in;
      for (int i = 0; i < phr_pkg::LANES; i++) begin
         priority if (t1_ff[i] < 9'd64) begin
            seg_in[i] = phr_pkg::SEG_RISE;
         end else if (t1_ff[i] < 9'd192) begin
            seg_in[i] = phr_pkg::SEG_HIGH;
         end else if (t1_ff[i] < 9'd256) begin
            seg_in[i] = phr_pkg::SEG_FALL;
         end else begin
            seg_in[i] = phr_pkg::SEG_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         a2_ff    <= a_in;
         p2_ff    <= p_in;
         span2_ff <= span_in;
         seg2_ff  <= seg_in;
         t2_ff    <= t1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: one small multiply per channel for the sloped pieces, and the
   // base level scaled by 64.
   // ------------------------------------------------------------------------
   logic [17:0] prod_in [phr_pkg::LANES];
   logic [17:0] prod3_ff [phr_pkg::LANES];
   logic [16:0] base_in [phr_pkg::LANES];
   logic [16:0] base3_ff [phr_pkg::LANES];

   always_comb begin
      logic [6:0] hue_gap [phr_pkg::LANES];
      for (int i = 0; i < phr_pkg::LANES; i++) begin
         unique case (seg2_ff[i])
            phr_pkg::SEG_RISE: begin
               hue_gap[i] = t2_ff[i][6:0];
               base_in[i] = {p2_ff, 6'b000000};
            end
            phr_pkg::SEG_HIGH: begin
               hue_gap[i] = 7'd0;
               base_in[i] = {a2_ff, 6'b000000};
            end
            phr_pkg::SEG_FALL: begin
               hue_gap[i] = 7'(9'd256 - t2_ff[i]);
               base_in[i] = {p2_ff, 6'b000000};
            end
            default: begin
               hue_gap[i] = 7'd0;
               base_in[i] = {p2_ff, 6'b000000};
            end
         endcase
         prod_in[i] = 18'(span2_ff) * 18'(hue_gap[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         prod3_ff <= prod_in;
         base3_ff <= base_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: add, scale to 0..256 by dropping nine bits, clamp to 255.
   // This is also the output register.
   // ------------------------------------------------------------------------
   phr_pkg::chan_type chan_in [phr_pkg::LANES];
   phr_pkg::chan_type chan4_ff [phr_pkg::LANES];

   always_comb begin
      logic [17:0] sum;
      for (int i = 0; i < phr_pkg::LANES; i++) begin
         sum        = 18'(base3_ff[i]) + prod3_ff[i];
         chan_in[i] = (sum[17:9] > 9'd255) ? 8'd255 : sum[16:9];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         chan4_ff <= chan_in;
      end
   end

   assign rsp_beat.valid = v4_ff;
   assign rsp_beat.red   = chan4_ff[0];
   assign rsp_beat.green = chan4_ff[1];
   assign rsp_beat.blue  = chan4_ff[2];

`ifndef SYNTH
   // The top level can never be below the bottom level.
   assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (a2_ff >= p2_ff))
      else $error("HSL top level below bottom level");

   // Wrapped hue positions stay within one turn.
   assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (t1_ff[0] <= 9'd384 && t1_ff[1] <= 9'd384 && t1_ff[2] <= 9'd384))
      else $error("hue position outside one turn");

   // Back-pressure on the input only comes from a full pipe held at the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_beat.ready |-> (rsp_beat.valid && !rsp_beat.ready && v1_ff && v2_ff && v3_ff))
      else $error("input stalled while pipeline had room");
`endif

endmodule
